// ----- hdl/chte_pkg.sv -----
package chte_pkg;

	// Operation codes carried in the func field.
	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_LOOKUP = 2'd1;
	localparam logic [1:0] FUNC_REMOVE = 2'd2;

	// Status codes returned with each result.
	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_PRESENT  = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_FOUND    = 3'd3;
	localparam logic [2:0] ST_MISSING  = 3'd4;
	localparam logic [2:0] ST_REMOVED  = 3'd5;

	// Fixed field widths of the request and the result.
	localparam int KEY_W = 64;
	localparam int LEN_W = 4;
	localparam int HASH_W = 32;
	localparam int VAL_W = 32;

	typedef struct packed {
		logic [1:0]       func;
		logic [KEY_W-1:0] key_bytes;
		logic [LEN_W-1:0] key_length;
		logic [VAL_W-1:0] value_in;
	} req_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [VAL_W-1:0] value_out;
	} rsp_t;

	// Status handed from the hash unit to the table sequencer.
	typedef struct packed {
		logic              done;
		logic [HASH_W-1:0] hash;
	} hash_stat_t;

endpackage

// ----- hdl/chte_ram.sv -----
module chte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/chte_hash.sv -----
module chte_hash (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [chte_pkg::KEY_W-1:0]        key,
	input  logic [chte_pkg::LEN_W-1:0]        len,
	output chte_pkg::hash_stat_t              stat
);

	logic [chte_pkg::HASH_W-1:0] h_q;
	logic [chte_pkg::LEN_W-1:0]  cnt_q;
	logic [chte_pkg::KEY_W-1:0]  key_q;
	logic                        busy_q;
	logic                        done_q;
	logic [7:0]                  byte_sel;
	logic [chte_pkg::HASH_W-1:0] b_ext;
	logic [2:0]                  idx;

	// The byte folded this cycle, sign-extended.
	assign idx = 3'(cnt_q - 4'd1);
	assign byte_sel = key_q[8*idx +: 8];
	assign b_ext = {{24{byte_sel[7]}}, byte_sel};

	// One byte per cycle, last byte first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			h_q <= '0;
			key_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= len;
				h_q <= 32'(len);
				key_q <= key;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					h_q <= h_q ^ ((h_q << 5) + (h_q >> 2) + b_ext);
					cnt_q <= cnt_q - 4'd1;
				end
			end
		end
	end

	assign stat.done = done_q;
	assign stat.hash = h_q;

endmodule

// ----- hdl/coalesced_hash_table_engine.sv -----
// Channel   Direction  Payload             Handshake
// req       in         chte_pkg::req_t     req_valid / req_stall
// rsp       out        chte_pkg::rsp_t     rsp_valid / rsp_stall
// One request at a time: the key is hashed byte by byte, then each slot visited
// on chain walks and on the upward free-slot scan passes read, wait and decode
// states, plus one state per write; the slot memory has a single read port.
// After reset a clearing pass over all TABLE_SLOTS slots resets the links first.
// A waiting result holds req_stall high until it is taken.
module coalesced_hash_table_engine #(
	parameter int TABLE_SLOTS = 256,
	parameter int KEY_BYTES = 8,
	parameter int VALUE_BITS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  chte_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output chte_pkg::rsp_t  rsp
);

	localparam int AW = $clog2(TABLE_SLOTS);
	localparam int PW = AW + 1;
	localparam logic [PW-1:0] NIL = PW'(TABLE_SLOTS);
	localparam int VB = (VALUE_BITS > 32) ? 32 : VALUE_BITS;
	// Entry: used, key, len, hash, value, link.
	localparam int EW = 1 + 64 + 4 + 32 + VB + PW;

	typedef struct packed {
		logic          used;
		logic [63:0]   key;
		logic [3:0]    len;
		logic [31:0]   hash;
		logic [VB-1:0] value;
		logic [PW-1:0] link;
	} ent_t;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_HASH, S_RD, S_WAIT, S_DEC,
		S_MV_WR, S_RL_RD, S_RL_WAIT, S_RL_DEC, S_HOME_WR,
		S_WK_RD, S_WK_WAIT, S_WK_DEC, S_AP_WR,
		S_FS_RD, S_FS_WAIT, S_FS_DEC,
		S_RM_NX_RD, S_RM_NX_WAIT, S_RM_CLR, S_OUT
	} st_t;

	st_t state_q;
	logic [1:0]   func_q;
	logic [63:0]  key_q;
	logic [3:0]   len_q;
	logic [VB-1:0] val_q;
	logic [31:0]  h_q;
	logic [PW-1:0] free_q, cur_q, prev_q, tgt_q, f_q;
	logic [PW:0]  n_q;
	logic         fs_store_q;
	logic [2:0]   st_q;
	logic [31:0]  vo_q;
	ent_t         ent_q, moved_q;
	logic [AW-1:0] clr_q;

	logic we, hstart;
	logic [AW-1:0] waddr, raddr;
	ent_t wdata, rdata;
	logic [EW-1:0] rdata_raw;
	chte_pkg::hash_stat_t hstat;
	logic [3:0]  len_c;
	logic [63:0] key_c;
	logic [AW-1:0] home;
	logic        match;
	logic        evict;

	chte_ram #(.WIDTH(EW), .DEPTH(TABLE_SLOTS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata_raw)
	);
	assign rdata = ent_t'(rdata_raw);

	// Clamp the key length and mask unused bytes on entry.
	always_comb begin
		len_c = (req.key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : req.key_length;
		key_c = '0;
		for (int i = 0; i < 8; i++) begin
			if (i < int'(len_c)) begin
				key_c[8*i +: 8] = req.key_bytes[8*i +: 8];
			end
		end
	end

	assign hstart = (state_q == S_IDLE) && req_valid;

	chte_hash u_hash (
		.clk(clk), .arst_n(arst_n), .start(hstart),
		.key(key_c), .len(len_c), .stat(hstat)
	);

	assign home = h_q[AW-1:0];
	assign match = rdata.used && rdata.hash == h_q && rdata.len == len_q &&
		rdata.key == key_q;
	// The home occupant was moved away and the new key takes the home slot.
	assign evict = (tgt_q == {1'b0, home}) && moved_q.used &&
		(moved_q.hash[AW-1:0] != home);
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = (state_q == S_OUT);
	assign rsp.status = st_q;
	assign rsp.value_out = vo_q;

	// Memory port control.
	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = ent_q;
		raddr = cur_q[AW-1:0];
		unique case (state_q)
			S_CLEAR: begin
				we = 1'b1;
				waddr = clr_q;
				wdata = '0;
				wdata.link = NIL;
			end
			S_MV_WR: begin
				we = 1'b1;
				waddr = f_q[AW-1:0];
				wdata = moved_q;
			end
			S_HOME_WR: begin
				we = 1'b1;
				waddr = home;
				wdata.used = 1'b1;
				wdata.key = key_q;
				wdata.len = len_q;
				wdata.hash = h_q;
				wdata.value = val_q;
				wdata.link = NIL;
			end
			S_AP_WR: begin
				we = 1'b1;
				waddr = f_q[AW-1:0];
				wdata.used = 1'b1;
				wdata.key = key_q;
				wdata.len = len_q;
				wdata.hash = h_q;
				wdata.value = val_q;
				wdata.link = NIL;
			end
			S_RL_DEC, S_WK_DEC, S_RM_NX_WAIT, S_RM_CLR, S_DEC: begin
				we = 1'b0;
			end
			default: we = 1'b0;
		endcase
		// Link rewrites and clears are issued from registered commands.
		if (state_q == S_RL_DEC && rdata.link == tgt_q) begin
			we = 1'b1;
			waddr = cur_q[AW-1:0];
			wdata = rdata;
			wdata.link = f_q;
		end
		if (state_q == S_RM_CLR) begin
			we = 1'b1;
			waddr = tgt_q[AW-1:0];
			wdata = ent_q;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			free_q <= '0;
			func_q <= '0; key_q <= '0; len_q <= '0; val_q <= '0; h_q <= '0;
			cur_q <= '0; prev_q <= '0; tgt_q <= '0; f_q <= '0; n_q <= '0;
			fs_store_q <= 1'b0; st_q <= '0; vo_q <= '0;
			ent_q <= '0; moved_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(TABLE_SLOTS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_valid) begin
						func_q <= req.func;
						key_q <= key_c;
						len_q <= len_c;
						val_q <= VB'(req.value_in);
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (hstat.done) begin
						h_q <= hstat.hash;
						cur_q <= {1'b0, hstat.hash[AW-1:0]};
						prev_q <= NIL;
						n_q <= '0;
						vo_q <= '0;
						if (func_q == chte_pkg::FUNC_INSERT || func_q == chte_pkg::FUNC_LOOKUP
							|| func_q == chte_pkg::FUNC_REMOVE) begin
							state_q <= S_RD;
						end else begin
							st_q <= chte_pkg::ST_MISSING;
							state_q <= S_OUT;
						end
					end
				end
				S_RD: state_q <= S_WAIT;
				S_WAIT: state_q <= S_DEC;
				S_DEC: begin
					if (func_q == chte_pkg::FUNC_INSERT) begin
						if (!rdata.used) begin
							// Home slot empty: write it directly.
							st_q <= chte_pkg::ST_INSERTED;
							if ({1'b0, home} == free_q) begin
								f_q <= free_q;
								fs_store_q <= 1'b0;
								cur_q <= free_q + 1'b1;
								state_q <= (free_q + 1'b1 >= NIL) ? S_HOME_WR : S_FS_RD;
								if (free_q + 1'b1 >= NIL) free_q <= NIL;
							end else begin
								state_q <= S_HOME_WR;
							end
						end else if (rdata.hash[AW-1:0] != home) begin
							// Occupant is displaced to the free slot.
							if (free_q >= NIL) begin
								st_q <= chte_pkg::ST_FULL;
								state_q <= S_OUT;
							end else begin
								moved_q <= rdata;
								f_q <= free_q;
								tgt_q <= {1'b0, home};
								state_q <= S_MV_WR;
							end
						end else begin
							state_q <= S_WK_DEC;
						end
					end else begin
						if (!rdata.used || rdata.hash[AW-1:0] != home) begin
							st_q <= chte_pkg::ST_MISSING;
							state_q <= S_OUT;
						end else begin
							state_q <= S_WK_DEC;
						end
					end
				end
				S_MV_WR: begin
					cur_q <= {1'b0, moved_q.hash[AW-1:0]};
					n_q <= '0;
					state_q <= S_RL_RD;
				end
				S_RL_RD: state_q <= S_RL_WAIT;
				S_RL_WAIT: state_q <= S_RL_DEC;
				S_RL_DEC: begin
					n_q <= n_q + 1'b1;
					if (rdata.link == tgt_q || rdata.link >= NIL
						|| n_q == (PW+1)'(TABLE_SLOTS - 1)) begin
						// Relink done: advance free pointer, then write home.
						st_q <= chte_pkg::ST_INSERTED;
						fs_store_q <= 1'b0;
						cur_q <= f_q + 1'b1;
						if (f_q + 1'b1 >= NIL) begin
							free_q <= NIL;
							state_q <= S_HOME_WR;
						end else begin
							state_q <= S_FS_RD;
						end
					end else begin
						cur_q <= rdata.link;
						state_q <= S_RL_RD;
					end
				end
				S_HOME_WR: state_q <= S_OUT;
				S_WK_RD: state_q <= S_WK_WAIT;
				S_WK_WAIT: state_q <= S_WK_DEC;
				S_WK_DEC: begin
					n_q <= n_q + 1'b1;
					if (match) begin
						if (func_q == chte_pkg::FUNC_INSERT) begin
							st_q <= chte_pkg::ST_PRESENT;
							state_q <= S_OUT;
						end else if (func_q == chte_pkg::FUNC_LOOKUP) begin
							st_q <= chte_pkg::ST_FOUND;
							vo_q <= 32'(rdata.value);
							state_q <= S_OUT;
						end else begin
							st_q <= chte_pkg::ST_REMOVED;
							if (prev_q < NIL) begin
								// Unlink: predecessor takes our link.
								ent_q <= ent_t'({moved_q[EW-1:PW], rdata.link});
								tgt_q <= prev_q;
								if (free_q > cur_q) free_q <= cur_q;
								f_q <= cur_q;
								fs_store_q <= 1'b1;
								state_q <= S_RM_CLR;
							end else if (rdata.link < NIL) begin
								tgt_q <= cur_q;
								cur_q <= rdata.link;
								state_q <= S_RM_NX_RD;
							end else begin
								ent_q <= ent_t'({1'b0, rdata[EW-2:PW], NIL});
								tgt_q <= cur_q;
								fs_store_q <= 1'b0;
								state_q <= S_RM_CLR;
							end
						end
					end else if (rdata.link >= NIL || n_q == (PW+1)'(TABLE_SLOTS - 1)) begin
						if (func_q == chte_pkg::FUNC_INSERT) begin
							if (free_q >= NIL) begin
								st_q <= chte_pkg::ST_FULL;
								state_q <= S_OUT;
							end else begin
								// Append: rewrite tail link, then fill free slot.
								ent_q <= ent_t'({rdata[EW-1:PW], free_q});
								tgt_q <= cur_q;
								f_q <= free_q;
								st_q <= chte_pkg::ST_INSERTED;
								fs_store_q <= 1'b0;
								state_q <= S_RM_CLR;
							end
						end else begin
							st_q <= chte_pkg::ST_MISSING;
							state_q <= S_OUT;
						end
					end else begin
						moved_q <= rdata;
						prev_q <= cur_q;
						cur_q <= rdata.link;
						state_q <= S_WK_RD;
					end
				end
				S_RM_NX_RD: state_q <= S_RM_NX_WAIT;
				S_RM_NX_WAIT: state_q <= S_FS_DEC;
				S_RM_CLR: begin
					// Shared single-entry write, then the follow-on step.
					if (func_q == chte_pkg::FUNC_INSERT) begin
						cur_q <= f_q + 1'b1;
						if (f_q + 1'b1 >= NIL) begin
							free_q <= NIL;
							state_q <= S_AP_WR;
						end else begin
							state_q <= S_FS_RD;
						end
					end else if (fs_store_q) begin
						// Clear the unlinked slot next.
						ent_q <= ent_t'({(EW-PW)'(0), NIL});
						tgt_q <= f_q;
						fs_store_q <= 1'b0;
						state_q <= S_RM_CLR;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_FS_RD: state_q <= S_FS_WAIT;
				S_FS_WAIT: state_q <= S_FS_DEC;
				S_FS_DEC: begin
					if (func_q == chte_pkg::FUNC_REMOVE) begin
						// Head removal: pull next entry up, then clear it.
						ent_q <= rdata;
						if (free_q > cur_q) free_q <= cur_q;
						f_q <= cur_q;
						fs_store_q <= 1'b1;
						state_q <= S_RM_CLR;
					end else if (!rdata.used) begin
						free_q <= cur_q;
						state_q <= (evict || f_q == {1'b0, home}) ? S_HOME_WR : S_AP_WR;
					end else if (cur_q + 1'b1 >= NIL) begin
						free_q <= NIL;
						state_q <= (evict || f_q == {1'b0, home}) ? S_HOME_WR : S_AP_WR;
					end else begin
						cur_q <= cur_q + 1'b1;
						state_q <= S_FS_RD;
					end
				end
				S_AP_WR: state_q <= S_OUT;
				S_OUT: begin
					if (!rsp_stall) begin
						moved_q <= '0;
						tgt_q <= NIL;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- test/coalesced_hash_table_engine_tb.sv -----
module coalesced_hash_table_engine_tb;
	import chte_pkg::*;

	localparam int SLOTS = 256;
	localparam int NIL = SLOTS;
	localparam int POOL = 320;
	localparam int RANDOM_ITEMS = 1400;
	localparam int CYCLE_LIMIT = 4000000;

	// Mirror of the slot table; works out the response of every accepted request.
	class hash_table_scoreboard;
		bit used[SLOTS];
		logic [63:0] skey[SLOTS];
		int slen[SLOTS];
		logic [31:0] shash[SLOTS];
		int slink[SLOTS];
		logic [31:0] sval[SLOTS];
		int free_ptr;
		rsp_t pending[$];
		int errors;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				used[i] = 0;
				slink[i] = NIL;
			end
			free_ptr = 0;
			errors = 0;
		endfunction

		function logic [31:0] fold_hash(logic [63:0] key, int len);
			logic [31:0] h;
			logic [7:0] b;
			h = 32'(len);
			for (int i = len; i >= 1; i--) begin
				b = key[8*(i-1) +: 8];
				h = h ^ ((h << 5) + (h >> 2) + {{24{b[7]}}, b});
			end
			return h;
		endfunction

		function bit matches_slot(int s, logic [63:0] key, int len, logic [31:0] h);
			return used[s] && shash[s] == h && slen[s] == len && skey[s] == key;
		endfunction

		function void bump_free();
			if (free_ptr >= NIL) begin
				free_ptr = NIL;
				return;
			end
			for (int i = free_ptr + 1; i < NIL; i++) begin
				if (!used[i]) begin
					free_ptr = i;
					return;
				end
			end
			free_ptr = NIL;
		endfunction

		function void put(int s, logic [63:0] key, int len, logic [31:0] h, logic [31:0] v);
			used[s] = 1;
			skey[s] = key;
			slen[s] = len;
			shash[s] = h;
			sval[s] = v;
			slink[s] = NIL;
		endfunction

		function void move_slot(int d, int s);
			used[d] = used[s];
			skey[d] = skey[s];
			slen[d] = slen[s];
			shash[d] = shash[s];
			sval[d] = sval[s];
			slink[d] = slink[s];
		endfunction

		function logic [2:0] insert_key(logic [63:0] key, int len, logic [31:0] h,
				logic [31:0] v);
			int pos;
			int cur;
			int f;
			pos = h & (SLOTS - 1);
			if (!used[pos]) begin
				if (pos == free_ptr)
					bump_free();
				put(pos, key, len, h, v);
				return ST_INSERTED;
			end
			// The occupant lives away from its home: evict it to the free slot.
			if ((shash[pos] & (SLOTS - 1)) != pos) begin
				f = free_ptr;
				if (f >= NIL)
					return ST_FULL;
				move_slot(f, pos);
				cur = shash[pos] & (SLOTS - 1);
				for (int n = 0; n < NIL; n++) begin
					if (slink[cur] == pos) begin
						slink[cur] = f;
						break;
					end
					if (slink[cur] >= NIL)
						break;
					cur = slink[cur];
				end
				bump_free();
				put(pos, key, len, h, v);
				return ST_INSERTED;
			end
			// Walk the home chain looking for a duplicate.
			cur = pos;
			for (int n = 0; n < NIL; n++) begin
				if (matches_slot(cur, key, len, h))
					return ST_PRESENT;
				if (slink[cur] >= NIL)
					break;
				cur = slink[cur];
			end
			if (free_ptr >= NIL)
				return ST_FULL;
			f = free_ptr;
			slink[cur] = f;
			bump_free();
			put(f, key, len, h, v);
			return ST_INSERTED;
		endfunction

		function logic [2:0] search_key(logic [63:0] key, int len, logic [31:0] h,
				bit drop, output logic [31:0] v);
			int pos;
			int cur;
			int prev;
			int nx;
			pos = h & (SLOTS - 1);
			cur = pos;
			prev = NIL;
			v = '0;
			if (!used[pos] || (shash[pos] & (SLOTS - 1)) != pos)
				return ST_MISSING;
			for (int n = 0; n < NIL; n++) begin
				if (matches_slot(cur, key, len, h)) begin
					if (!drop) begin
						v = sval[cur];
						return ST_FOUND;
					end
					if (prev < NIL) begin
						slink[prev] = slink[cur];
						if (free_ptr > cur)
							free_ptr = cur;
						used[cur] = 0;
						slink[cur] = NIL;
					end else begin
						// Removing the chain head pulls its successor into place.
						nx = slink[cur];
						if (nx < NIL) begin
							move_slot(cur, nx);
							if (free_ptr > nx)
								free_ptr = nx;
							used[nx] = 0;
							slink[nx] = NIL;
						end else begin
							used[cur] = 0;
							slink[cur] = NIL;
						end
					end
					return ST_REMOVED;
				end
				if (slink[cur] >= NIL)
					break;
				prev = cur;
				cur = slink[cur];
			end
			return ST_MISSING;
		endfunction

		function void note_request(req_t r);
			int len;
			logic [63:0] key;
			logic [31:0] h;
			logic [31:0] v;
			rsp_t e;
			len = int'(r.key_length);
			if (len > 8)
				len = 8;
			key = (len == 8) ? r.key_bytes : (r.key_bytes & ((64'h1 << (8 * len)) - 1));
			h = fold_hash(key, len);
			v = '0;
			case (r.func)
				FUNC_INSERT: e.status = insert_key(key, len, h, r.value_in);
				FUNC_LOOKUP: e.status = search_key(key, len, h, 0, v);
				FUNC_REMOVE: e.status = search_key(key, len, h, 1, v);
				default: e.status = ST_MISSING;
			endcase
			e.value_out = (e.status == ST_FOUND) ? v : '0;
			pending.push_back(e);
		endfunction

		function void check_response(rsp_t a);
			rsp_t e;
			if (pending.size() == 0) begin
				$error("unexpected response status=%0d value_out=%h", a.status, a.value_out);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, a.status);
				errors++;
			end
			if (a.value_out !== e.value_out) begin
				$error("value_out: expected %h, got %h", e.value_out, a.value_out);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	hash_table_scoreboard sb;
	int cycles;
	logic [63:0] pool_key[POOL];
	logic [3:0] pool_len[POOL];

	coalesced_hash_table_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Cycle count and the run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Response side: check accepted results, then pick the next stall.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(rsp);
		case ((cycles / 600) % 4)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= ($urandom_range(0, 1) == 0);
			2: rsp_stall <= ($urandom_range(0, 7) == 0) ? !rsp_stall : rsp_stall;
			default: rsp_stall <= ($urandom_range(0, 4) == 0);
		endcase
	end

	// Present one request and hold it until it is taken.
	task automatic send_request(req_t r);
		req <= r;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		sb.note_request(r);
	endtask

	task automatic send_fields(logic [1:0] f, logic [63:0] k, logic [3:0] l, logic [31:0] v);
		req_t r;
		r.func = f;
		r.key_bytes = k;
		r.key_length = l;
		r.value_in = v;
		send_request(r);
	endtask

	// Random gap after a burst, sometimes none at all.
	task automatic maybe_gap(inout int burst);
		if (burst > 0) begin
			burst--;
			return;
		end
		burst = $urandom_range(0, 12);
		if ($urandom_range(0, 2) != 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	initial begin
		int burst;
		int idx;
		int pick;
		int wait_cycles;
		logic [1:0] f;
		logic [63:0] k;
		logic [3:0] l;
		logic [63:0] m;
		sb = new();
		burst = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		for (int i = 0; i < POOL; i++) begin
			pool_len[i] = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 2)) :
				4'($urandom_range(1, 8));
			pool_key[i] = {$urandom, $urandom};
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty key, duplicates, long lengths, sign bytes, unknown func.
		send_fields(FUNC_INSERT, 64'hffff_ffff_ffff_ffff, 4'd0, 32'hffff_ffff);
		send_fields(FUNC_INSERT, 64'h0, 4'd0, 32'h1);
		send_fields(FUNC_LOOKUP, 64'h1234, 4'd0, 32'h0);
		send_fields(FUNC_INSERT, 64'hffff_ffff_ffff_ffff, 4'd15, 32'h0);
		send_fields(FUNC_LOOKUP, 64'hffff_ffff_ffff_ffff, 4'd8, 32'h0);
		send_fields(FUNC_INSERT, 64'h8080_8080_8080_8080, 4'd8, 32'h8000_0001);
		send_fields(FUNC_LOOKUP, 64'h8080_8080_8080_8080, 4'd9, 32'h0);
		send_fields(FUNC_INSERT, 64'h0, 4'd8, 32'h0);
		send_fields(FUNC_INSERT, 64'h7f, 4'd1, 32'h5555_aaaa);
		send_fields(FUNC_INSERT, 64'hff00_0000_0000_0080, 4'd1, 32'haaaa_5555);
		send_fields(FUNC_LOOKUP, 64'h80, 4'd1, 32'h0);
		send_fields(2'd3, 64'h7f, 4'd1, 32'hffff_ffff);
		send_fields(FUNC_LOOKUP, 64'h7f, 4'd1, 32'h0);
		send_fields(FUNC_REMOVE, 64'h7f, 4'd1, 32'h0);
		send_fields(FUNC_LOOKUP, 64'h7f, 4'd1, 32'h0);
		send_fields(FUNC_REMOVE, 64'h7f, 4'd1, 32'h0);
		send_fields(FUNC_REMOVE, 64'h0, 4'd0, 32'h0);
		send_fields(FUNC_LOOKUP, 64'h0, 4'd0, 32'h0);
		send_fields(FUNC_REMOVE, 64'hffff_ffff_ffff_ffff, 4'd8, 32'h0);
		send_fields(FUNC_LOOKUP, 64'h0, 4'd8, 32'h0);

		// Random: fill the table from a key pool, then drain it, with some noise.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			maybe_gap(burst);
			pick = $urandom_range(0, 99);
			if (n < RANDOM_ITEMS / 2)
				f = (pick < 70) ? FUNC_INSERT : (pick < 88) ? FUNC_LOOKUP :
					(pick < 97) ? FUNC_REMOVE : 2'd3;
			else
				f = (pick < 25) ? FUNC_INSERT : (pick < 55) ? FUNC_LOOKUP :
					(pick < 97) ? FUNC_REMOVE : 2'd3;
			idx = $urandom_range(0, POOL - 1);
			l = pool_len[idx];
			m = (l == 8) ? '1 : ((64'h1 << (8 * l)) - 1);
			// Bytes past the length are junk that must be ignored.
			k = (pool_key[idx] & m) | ({$urandom, $urandom} & ~m);
			if (l == 8 && $urandom_range(0, 3) == 0)
				l = 4'($urandom_range(9, 15));
			if ($urandom_range(0, 9) == 0) begin
				k = {$urandom, $urandom};
				l = 4'($urandom_range(0, 15));
			end
			send_fields(f, k, l, $urandom);
		end
		req_valid <= 1'b0;

		// Drain the outstanding responses, then watch for stray ones.
		while (sb.pending.size() != 0)
			@(posedge clk);
		wait_cycles = 3000;
		repeat (wait_cycles) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
